>>> rtl/sweep_prune_contact_tracker_defines.svh
// Assertion macros shared by the contact tracker RTL.
// Needs signals named clk and rst_n in the including scope.
`ifndef SWEEP_PRUNE_CONTACT_TRACKER_DEFINES_SVH
`define SWEEP_PRUNE_CONTACT_TRACKER_DEFINES_SVH
`ifndef SYNTHESIS
`define SPC_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spc check failed");
`define SPC_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spc check failed");
`else
`define SPC_ASSERT_IMP(name, ante, cons)
`define SPC_ASSERT_NXT(name, ante, cons)
`endif
`endif

>>> rtl/spc_pkg.sv
// Shared types and codes for the sweep-and-prune contact tracker.
// No dependencies.
`timescale 1ns / 1ps
package spc_pkg;
    localparam int IW = 6;

    localparam logic [1:0] OP_SEG   = 2'd0;
    localparam logic [1:0] OP_PT    = 2'd1;
    localparam logic [1:0] OP_SWEEP = 2'd2;
    localparam logic [1:0] OP_QUERY = 2'd3;

    localparam logic [1:0] KIND_MIN = 2'd0;
    localparam logic [1:0] KIND_MAX = 2'd1;
    localparam logic [1:0] KIND_PT  = 2'd2;

    localparam logic [13:0] SWAP_SAT  = 14'h3FFF;
    localparam logic [10:0] TOTAL_SAT = 11'd2047;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [IW-1:0]      item_index;
        logic [IW-1:0]      query_point;
        logic signed [31:0] a_x;
        logic signed [31:0] a_y;
        logic signed [31:0] b_x;
        logic signed [31:0] b_y;
        logic [30:0]        half_a;
        logic [30:0]        half_b;
    } cmd_t;

    typedef struct packed {
        logic        contact_present;
        logic [10:0] contact_total;
        logic [13:0] swap_total;
    } rsp_t;
endpackage

>>> rtl/spc_cmd_if.sv
// Command channel: valid/ready plus one command item.
// Depends on spc_pkg.
`timescale 1ns / 1ps
interface spc_cmd_if;
    logic          valid;
    logic          ready;
    spc_pkg::cmd_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> rtl/spc_rsp_if.sv
// Response channel: valid/ready plus one result item.
// Depends on spc_pkg.
`timescale 1ns / 1ps
interface spc_rsp_if;
    logic          valid;
    logic          ready;
    spc_pkg::rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> rtl/sweep_prune_contact_tracker.sv
// Point update runs S_PT, segment update S_U1 and S_U2, query S_Q_RD and S_Q, each then S_DONE.
// Sweep, per axis, over all L = 2*SEGMENTS+POINTS entries: each is loaded (S_LD_RD, S_LD_EN,
// S_LD_WR), then insertion-sorted (S_KEY_RD, S_KEY, S_NB_RD, S_NB, S_PLACE); a swap adds S_SHIFT,
// plus S_CT_RD and S_CT when it moves a point across a segment bound. One transaction at a time.
// Reset: asynchronous, active low; then a clearing pass over all 2^(ceil(log2 SEGMENTS)+ceil(log2
// POINTS)) contact-matrix entries (1024 by default) zeroes them before the first transaction.
`timescale 1ns / 1ps
`include "sweep_prune_contact_tracker_defines.svh"
module sweep_prune_contact_tracker #(
    parameter int SEGMENTS   = 16,
    parameter int POINTS     = 64,
    parameter int COORD_BITS = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    spc_cmd_if.sink   cmd,
    spc_rsp_if.source rsp
);
    import spc_pkg::*;

    // Sizes
    localparam int C    = COORD_BITS;
    localparam int LEN  = 2 * SEGMENTS + POINTS;
    localparam int LW   = $clog2(LEN);
    localparam int CW   = $clog2(LEN + 1);
    localparam int SW   = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
    localparam int PW   = (POINTS > 1) ? $clog2(POINTS) : 1;
    localparam int CAW  = SW + PW;
    localparam int NW   = $clog2(SEGMENTS * POINTS + 1);
    localparam int EW   = (C > 34) ? C : 34;
    localparam int OW   = 2 + IW + C;
    localparam int ODEP = 2 << LW;
    localparam int CDEP = 1 << CAW;
    localparam logic signed [EW-1:0] C_HI = EW'((64'sd1 <<< (C - 1)) - 64'sd1);
    localparam logic signed [EW-1:0] C_LO = ~C_HI;

    // Sequencer states
    localparam logic [4:0] S_CLR    = 5'd0;
    localparam logic [4:0] S_IDLE   = 5'd1;
    localparam logic [4:0] S_U1     = 5'd2;
    localparam logic [4:0] S_U2     = 5'd3;
    localparam logic [4:0] S_PT     = 5'd4;
    localparam logic [4:0] S_LD_RD  = 5'd5;
    localparam logic [4:0] S_LD_EN  = 5'd6;
    localparam logic [4:0] S_LD_WR  = 5'd7;
    localparam logic [4:0] S_KEY_RD = 5'd8;
    localparam logic [4:0] S_KEY    = 5'd9;
    localparam logic [4:0] S_NB_RD  = 5'd10;
    localparam logic [4:0] S_NB     = 5'd11;
    localparam logic [4:0] S_CT_RD  = 5'd12;
    localparam logic [4:0] S_CT     = 5'd13;
    localparam logic [4:0] S_SHIFT  = 5'd14;
    localparam logic [4:0] S_PLACE  = 5'd15;
    localparam logic [4:0] S_Q_RD   = 5'd16;
    localparam logic [4:0] S_Q      = 5'd17;
    localparam logic [4:0] S_DONE   = 5'd18;

    function automatic logic signed [C-1:0] sat_c(input logic signed [EW-1:0] v);
        if (v > C_HI)
        begin
            return C_HI[C-1:0];
        end
        else if (v < C_LO)
        begin
            return C_LO[C-1:0];
        end
        return v[C-1:0];
    endfunction

    // Control state
    logic [4:0]    state_reg;
    logic [CAW:0]  clr_reg;
    logic          axis_reg;
    logic [1:0]    init_reg;
    logic [CW-1:0] k_reg, j_reg, i_reg;
    logic [NW-1:0] count_reg;
    logic [13:0]   swaps_reg, last_swaps_reg;
    logic          res_vld_reg;
    logic [SEGMENTS-1:0] seg_vld_reg;
    logic [POINTS-1:0]   pt_vld_reg;

    // Payload registers
    cmd_t             item_reg;
    rsp_t             res_reg;
    logic             present_reg;
    logic             q_ok_reg;
    logic             bnd_vq_reg, pt_vq_reg;
    logic [1:0]       ld_kind_reg;
    logic [IW-1:0]    ld_idx_reg;
    logic [OW-1:0]    key_reg, sw_reg;
    logic [IW-1:0]    s_reg, p_reg;
    logic             add_reg;
    logic signed [EW-1:0] ext_reg [8];

    // Memory ports
    logic              ord_we;
    logic [LW:0]       ord_waddr, ord_raddr;
    logic [OW-1:0]     ord_wdata, ord_rdata;
    logic              bnd_we;
    logic [SW-1:0]     bnd_waddr, bnd_raddr;
    logic [4*C-1:0]    bnd_wdata, bnd_rdata, bnd_q;
    logic              pt_we;
    logic [PW-1:0]     pt_waddr, pt_raddr;
    logic [2*C-1:0]    pt_wdata, pt_rdata, pt_q;
    logic              ct_we;
    logic [CAW-1:0]    ct_waddr, ct_raddr;
    logic              ct_wdata, ct_rdata;

    spc_ram #(.WIDTH(OW), .DEPTH(ODEP)) u_order (
        .clk(clk), .we(ord_we), .waddr(ord_waddr), .wdata(ord_wdata),
        .raddr(ord_raddr), .rdata(ord_rdata));
    spc_ram #(.WIDTH(4 * C), .DEPTH(SEGMENTS)) u_bounds (
        .clk(clk), .we(bnd_we), .waddr(bnd_waddr), .wdata(bnd_wdata),
        .raddr(bnd_raddr), .rdata(bnd_rdata));
    spc_ram #(.WIDTH(2 * C), .DEPTH(POINTS)) u_points (
        .clk(clk), .we(pt_we), .waddr(pt_waddr), .wdata(pt_wdata),
        .raddr(pt_raddr), .rdata(pt_rdata));
    spc_ram #(.WIDTH(1), .DEPTH(CDEP)) u_contacts (
        .clk(clk), .we(ct_we), .waddr(ct_waddr), .wdata(ct_wdata),
        .raddr(ct_raddr), .rdata(ct_rdata));

    // Entries never written read as zero
    assign bnd_q = bnd_vq_reg ? bnd_rdata : '0;
    assign pt_q  = pt_vq_reg ? pt_rdata : '0;

    // Fields of the entry just read and of the held key
    logic [1:0]          rd_kind, key_kind;
    logic [IW-1:0]       rd_idx, key_idx;
    logic signed [C-1:0] rd_val, key_val;
    assign rd_kind  = ord_rdata[OW-1 -: 2];
    assign rd_idx   = ord_rdata[C +: IW];
    assign rd_val   = ord_rdata[C-1:0];
    assign key_kind = key_reg[OW-1 -: 2];
    assign key_idx  = key_reg[C +: IW];
    assign key_val  = key_reg[C-1:0];

    // Load-phase entry: the reset order until this list has been loaded once
    logic [1:0]    ld_kind;
    logic [IW-1:0] ld_idx;
    logic [CW-1:0] k_off;
    always_comb
    begin
        k_off = k_reg - CW'(2 * SEGMENTS);
        if (init_reg[axis_reg])
        begin
            ld_kind = rd_kind;
            ld_idx  = rd_idx;
        end
        else if (k_reg < CW'(2 * SEGMENTS))
        begin
            ld_kind = k_reg[0] ? KIND_MAX : KIND_MIN;
            ld_idx  = IW'(k_reg >> 1);
        end
        else
        begin
            ld_kind = KIND_PT;
            ld_idx  = IW'(k_off);
        end
    end

    // Endpoint value for the load phase
    logic signed [C-1:0] ld_val;
    always_comb
    begin
        unique case (ld_kind_reg)
            KIND_MIN: ld_val = axis_reg ? bnd_q[2*C-1:C] : bnd_q[4*C-1:3*C];
            KIND_MAX: ld_val = axis_reg ? bnd_q[C-1:0] : bnd_q[3*C-1:2*C];
            default:  ld_val = axis_reg ? pt_q[C-1:0] : pt_q[2*C-1:C];
        endcase
    end

    // Box test for the pair under a swap: x_min < px <= x_max, same in y
    logic signed [C-1:0] bx_min, bx_max, by_min, by_max, ppx, ppy;
    logic                hit;
    assign bx_min = bnd_q[4*C-1:3*C];
    assign bx_max = bnd_q[3*C-1:2*C];
    assign by_min = bnd_q[2*C-1:C];
    assign by_max = bnd_q[C-1:0];
    assign ppx    = pt_q[2*C-1:C];
    assign ppy    = pt_q[C-1:0];
    assign hit    = (ppx > bx_min) && (ppx <= bx_max) && (ppy > by_min) && (ppy <= by_max);

    logic ct_set, ct_clr;
    assign ct_set = (state_reg == S_CT) && add_reg && hit && !ct_rdata;
    assign ct_clr = (state_reg == S_CT) && !add_reg && ct_rdata;

    // Segment box from the registered node +/- half thickness terms
    logic signed [EW-1:0] mn_x, mx_x, mn_y, mx_y;
    always_comb
    begin
        mn_x = (ext_reg[0] < ext_reg[1]) ? ext_reg[0] : ext_reg[1];
        mx_x = (ext_reg[2] > ext_reg[3]) ? ext_reg[2] : ext_reg[3];
        mn_y = (ext_reg[4] < ext_reg[5]) ? ext_reg[4] : ext_reg[5];
        mx_y = (ext_reg[6] > ext_reg[7]) ? ext_reg[6] : ext_reg[7];
    end

    logic signed [EW-1:0] ax_e, ay_e, bx_e, by_e, ha_e, hb_e;
    assign ax_e = EW'(cmd.data.a_x);
    assign ay_e = EW'(cmd.data.a_y);
    assign bx_e = EW'(cmd.data.b_x);
    assign by_e = EW'(cmd.data.b_y);
    assign ha_e = $signed({{(EW - 31){1'b0}}, cmd.data.half_a});
    assign hb_e = $signed({{(EW - 31){1'b0}}, cmd.data.half_b});

    logic seg_ok, pt_ok;
    assign seg_ok = {1'b0, item_reg.item_index} < (IW + 1)'(SEGMENTS);
    assign pt_ok  = {1'b0, item_reg.item_index} < (IW + 1)'(POINTS);

    // Memory access per state
    always_comb
    begin
        ord_we    = 1'b0;
        ord_waddr = {axis_reg, i_reg[LW-1:0]};
        ord_wdata = key_reg;
        ord_raddr = {axis_reg, k_reg[LW-1:0]};
        bnd_we    = 1'b0;
        bnd_waddr = SW'(item_reg.item_index);
        bnd_wdata = {sat_c(mn_x), sat_c(mx_x), sat_c(mn_y), sat_c(mx_y)};
        bnd_raddr = SW'(s_reg);
        pt_we     = 1'b0;
        pt_waddr  = PW'(item_reg.item_index);
        pt_wdata  = {sat_c(EW'(item_reg.a_x)), sat_c(EW'(item_reg.a_y))};
        pt_raddr  = PW'(p_reg);
        ct_we     = 1'b0;
        ct_waddr  = {SW'(s_reg), PW'(p_reg)};
        ct_wdata  = ct_set;
        ct_raddr  = {SW'(s_reg), PW'(p_reg)};
        unique case (state_reg)
            S_CLR:
            begin
                ct_we    = 1'b1;
                ct_waddr = clr_reg[CAW-1:0];
                ct_wdata = 1'b0;
            end
            S_U2:    bnd_we = seg_ok;
            S_PT:    pt_we  = pt_ok;
            S_LD_EN:
            begin
                bnd_raddr = SW'(ld_idx);
                pt_raddr  = PW'(ld_idx);
            end
            S_LD_WR:
            begin
                ord_we    = 1'b1;
                ord_waddr = {axis_reg, k_reg[LW-1:0]};
                ord_wdata = {ld_kind_reg, ld_idx_reg, ld_val};
            end
            S_KEY_RD: ord_raddr = {axis_reg, j_reg[LW-1:0]};
            S_NB_RD:  ord_raddr = {axis_reg, LW'(i_reg - CW'(1))};
            S_CT:     ct_we = ct_set || ct_clr;
            S_SHIFT:
            begin
                ord_we    = 1'b1;
                ord_wdata = sw_reg;
            end
            S_PLACE:  ord_we = 1'b1;
            S_Q_RD:
                ct_raddr = {SW'(item_reg.item_index), PW'(item_reg.query_point)};
            default: ;
        endcase
    end

    assign cmd.ready = (state_reg == S_IDLE);
    assign rsp.valid = res_vld_reg;
    assign rsp.data  = res_reg;

    // Sequencer and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLR;
            clr_reg        <= '0;
            axis_reg       <= 1'b0;
            init_reg       <= '0;
            k_reg          <= '0;
            j_reg          <= '0;
            i_reg          <= '0;
            count_reg      <= '0;
            swaps_reg      <= '0;
            last_swaps_reg <= '0;
            res_vld_reg    <= 1'b0;
            seg_vld_reg    <= '0;
            pt_vld_reg     <= '0;
        end
        else
        begin
            // In S_DONE the result register is reloaded below instead
            if (rsp.valid && rsp.ready && (state_reg != S_DONE))
            begin
                res_vld_reg <= 1'b0;
            end
            if (ct_set)
            begin
                count_reg <= count_reg + NW'(1);
            end
            else if (ct_clr)
            begin
                count_reg <= count_reg - NW'(1);
            end
            if (bnd_we)
            begin
                seg_vld_reg[bnd_waddr] <= 1'b1;
            end
            if (pt_we)
            begin
                pt_vld_reg[pt_waddr] <= 1'b1;
            end
            unique case (state_reg)
                S_CLR:
                begin
                    clr_reg <= clr_reg + (CAW + 1)'(1);
                    if (clr_reg[CAW-1:0] == CAW'(CDEP - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (cmd.valid)
                    begin
                        unique case (cmd.data.opcode)
                            OP_SEG:   state_reg <= S_U1;
                            OP_PT:    state_reg <= S_PT;
                            OP_SWEEP:
                            begin
                                state_reg <= S_LD_RD;
                                axis_reg  <= 1'b0;
                                k_reg     <= '0;
                                swaps_reg <= '0;
                            end
                            default:  state_reg <= S_Q_RD;
                        endcase
                    end
                end
                S_U1:    state_reg <= S_U2;
                S_U2:    state_reg <= S_DONE;
                S_PT:    state_reg <= S_DONE;
                S_LD_RD: state_reg <= S_LD_EN;
                S_LD_EN: state_reg <= S_LD_WR;
                S_LD_WR:
                begin
                    k_reg <= k_reg + CW'(1);
                    if (k_reg == CW'(LEN - 1))
                    begin
                        init_reg[axis_reg] <= 1'b1;
                        j_reg              <= CW'(1);
                        state_reg          <= S_KEY_RD;
                    end
                    else
                    begin
                        state_reg <= S_LD_RD;
                    end
                end
                S_KEY_RD: state_reg <= S_KEY;
                S_KEY:
                begin
                    i_reg     <= j_reg;
                    state_reg <= S_NB_RD;
                end
                S_NB_RD:  state_reg <= (i_reg == '0) ? S_PLACE : S_NB;
                S_NB:
                begin
                    if (rd_val > key_val)
                    begin
                        state_reg <= ((rd_kind == KIND_PT) != (key_kind == KIND_PT)) ?
                                     S_CT_RD : S_SHIFT;
                    end
                    else
                    begin
                        state_reg <= S_PLACE;
                    end
                end
                S_CT_RD:  state_reg <= S_CT;
                S_CT:     state_reg <= S_SHIFT;
                S_SHIFT:
                begin
                    i_reg <= i_reg - CW'(1);
                    if (swaps_reg != SWAP_SAT)
                    begin
                        swaps_reg <= swaps_reg + 14'd1;
                    end
                    state_reg <= S_NB_RD;
                end
                S_PLACE:
                begin
                    j_reg <= j_reg + CW'(1);
                    if (j_reg != CW'(LEN - 1))
                    begin
                        state_reg <= S_KEY_RD;
                    end
                    else if (!axis_reg)
                    begin
                        axis_reg  <= 1'b1;
                        k_reg     <= '0;
                        state_reg <= S_LD_RD;
                    end
                    else
                    begin
                        last_swaps_reg <= swaps_reg;
                        state_reg      <= S_DONE;
                    end
                end
                S_Q_RD: state_reg <= S_Q;
                S_Q:    state_reg <= S_DONE;
                S_DONE:
                begin
                    if (!res_vld_reg || rsp.ready)
                    begin
                        res_vld_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        bnd_vq_reg <= seg_vld_reg[bnd_raddr];
        pt_vq_reg  <= pt_vld_reg[pt_raddr];
        if (state_reg == S_IDLE && cmd.valid)
        begin
            item_reg    <= cmd.data;
            present_reg <= 1'b0;
            ext_reg[0]  <= ax_e - ha_e;
            ext_reg[1]  <= bx_e - hb_e;
            ext_reg[2]  <= ax_e + ha_e;
            ext_reg[3]  <= bx_e + hb_e;
            ext_reg[4]  <= ay_e - ha_e;
            ext_reg[5]  <= by_e - hb_e;
            ext_reg[6]  <= ay_e + ha_e;
            ext_reg[7]  <= by_e + hb_e;
        end
        if (state_reg == S_Q_RD)
        begin
            q_ok_reg <= seg_ok && ({1'b0, item_reg.query_point} < (IW + 1)'(POINTS));
        end
        if (state_reg == S_Q)
        begin
            present_reg <= q_ok_reg && ct_rdata;
        end
        if (state_reg == S_LD_EN)
        begin
            ld_kind_reg <= ld_kind;
            ld_idx_reg  <= ld_idx;
        end
        if (state_reg == S_KEY)
        begin
            key_reg <= ord_rdata;
        end
        if (state_reg == S_NB)
        begin
            sw_reg  <= ord_rdata;
            // Pair: one side a point, the other a segment bound
            s_reg   <= (key_kind == KIND_PT) ? rd_idx : key_idx;
            p_reg   <= (key_kind == KIND_PT) ? key_idx : rd_idx;
            add_reg <= (key_kind == KIND_PT) ? (rd_kind == KIND_MAX) : (key_kind == KIND_MIN);
        end
        if (state_reg == S_DONE && (!res_vld_reg || rsp.ready))
        begin
            res_reg.contact_present <= present_reg;
            res_reg.contact_total   <= (32'(count_reg) > 32'(TOTAL_SAT)) ?
                                       TOTAL_SAT : 11'(count_reg);
            res_reg.swap_total      <= last_swaps_reg;
        end
    end

    // Checks
    `SPC_ASSERT_IMP(a_count_range, 1'b1, 32'(count_reg) <= 32'(SEGMENTS * POINTS))
    `SPC_ASSERT_IMP(a_clear_blocks, state_reg == S_CLR, !cmd.ready)
    `SPC_ASSERT_IMP(a_sort_bound, state_reg == S_NB_RD, (i_reg <= j_reg) && (j_reg < CW'(LEN)))
    `SPC_ASSERT_NXT(a_swaps_grow, state_reg == S_SHIFT, swaps_reg >= $past(swaps_reg))
endmodule

>>> rtl/spc_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
module spc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule
